/* sv/gcd_lcm_unit_assert.svh */
// Assertion macros for the gcd_lcm_unit checker
`ifndef GCD_LCM_UNIT_ASSERT_SVH
`define GCD_LCM_UNIT_ASSERT_SVH

// Same-cycle implication
`define GLU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gcd_lcm_unit check failed");

// Next-cycle implication
`define GLU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gcd_lcm_unit check failed");

`endif

/* sv/glu_pkg.sv */
// Shared constants and controller/datapath interface types for gcd_lcm_unit
package glu_pkg;

   localparam int OPERAND_BITS = 16;
   localparam int RESULT_BITS  = 2 * OPERAND_BITS;
   localparam int SHIFT_BITS   = $clog2(OPERAND_BITS);

   typedef struct packed {
      logic load;
      logic gcd_step;
      logic div_load;
      logic div_step;
      logic mul_step;
   } glu_cmd_type;

   typedef struct packed {
      logic gcd_zero;
      logic div_last;
   } glu_sts_type;

endpackage

/* sv/glu_dpath.sv */
// Datapath: binary GCD, restoring divider and final multiply
module glu_dpath
   import glu_pkg::*;
(
   input  logic                    clock,
   input  glu_cmd_type             cmd,
   output glu_sts_type             sts,
   input  logic [OPERAND_BITS-1:0] req_first_operand,
   input  logic [OPERAND_BITS-1:0] req_second_operand,
   output logic [OPERAND_BITS-1:0] rsp_common_divisor,
   output logic [RESULT_BITS-1:0]  rsp_common_multiple
);

   logic [OPERAND_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic [SHIFT_BITS-1:0]   k_ff, k_in;
   logic [OPERAND_BITS-1:0] n_ff, n_in, m_ff, m_in;
   logic [OPERAND_BITS-1:0] gcd_ff, gcd_in;
   logic [OPERAND_BITS-1:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [SHIFT_BITS-1:0]   cnt_ff, cnt_in;
   logic [RESULT_BITS-1:0]  prod_ff, prod_in;
   logic [OPERAND_BITS:0]   rem_shift;
   logic [OPERAND_BITS-1:0] a_minus_b, b_minus_a;

   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;
   assign rem_shift = {rem_ff, quo_ff[OPERAND_BITS-1]};

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      n_in    = n_ff;
      m_in    = m_ff;
      gcd_in  = gcd_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      if (cmd.load) begin
         n_in = req_first_operand;
         m_in = req_second_operand;
         k_in = '0;
         if (req_first_operand < OPERAND_BITS'(2)) begin
            a_in = OPERAND_BITS'(1);
            b_in = '0;
         end else begin
            a_in = req_first_operand;
            b_in = req_second_operand;
         end
      end
      if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_BITS'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = a_minus_b >> 1;
         end else begin
            b_in = b_minus_a >> 1;
         end
      end
      if (cmd.div_load) begin
         gcd_in = (a_ff | b_ff) << k_ff;
         rem_in = '0;
         quo_in = n_ff;
         cnt_in = SHIFT_BITS'(OPERAND_BITS - 1);
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, gcd_ff}) begin
            rem_in = OPERAND_BITS'(rem_shift - {1'b0, gcd_ff});
            quo_in = {quo_ff[OPERAND_BITS-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[OPERAND_BITS-1:0];
            quo_in = {quo_ff[OPERAND_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - SHIFT_BITS'(1);
      end
      if (cmd.mul_step) begin
         prod_in = RESULT_BITS'(quo_ff) * RESULT_BITS'(m_ff);
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
      m_ff    <= m_in;
      gcd_ff  <= gcd_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   assign sts.gcd_zero = (a_ff == '0) || (b_ff == '0);
   assign sts.div_last = (cnt_ff == '0);

   assign rsp_common_divisor  = gcd_ff;
   assign rsp_common_multiple = prod_ff;

endmodule

/* sv/glu_ctrl.sv */
// Controller: sequences GCD, divide and multiply phases
module glu_ctrl
   import glu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   output logic        rsp_valid,
   output glu_cmd_type cmd,
   input  glu_sts_type sts
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_GCD  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } glu_state_type;

   glu_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_zero) begin
               cmd.div_load = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

/* sv/gcd_lcm_unit.sv */
// Top level of gcd_lcm_unit: controller plus datapath
//
// Computes the greatest common divisor and least common multiple of two
// unsigned operands. A transfer is taken when start is high and busy is low;
// busy then stays high through the result strobe. The result appears on the
// rsp_ ports for exactly one cycle with rsp_valid high and is not held, so
// the receiver must capture it in that cycle. A transfer passes through the
// binary GCD loop (one shift or subtract per cycle, step count set by the
// operand bit lengths), the one-bit-per-cycle restoring divider, a multiply
// state and an output state. If the first operand is 0 or 1 the divisor is
// 1; if only the second operand is 0 the divisor is the first operand and
// the multiple is 0.
module gcd_lcm_unit
   import glu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [OPERAND_BITS-1:0] req_first_operand,
   input  logic [OPERAND_BITS-1:0] req_second_operand,
   output logic                    rsp_valid,
   output logic [OPERAND_BITS-1:0] rsp_common_divisor,
   output logic [RESULT_BITS-1:0]  rsp_common_multiple
);

   glu_cmd_type cmd;
   glu_sts_type sts;

   glu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   glu_dpath u_dpath (
      .clock               (clock),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_first_operand   (req_first_operand),
      .req_second_operand  (req_second_operand),
      .rsp_common_divisor  (rsp_common_divisor),
      .rsp_common_multiple (rsp_common_multiple)
   );

endmodule

/* sv/glu_check.sv */
// Port-level checker for gcd_lcm_unit and its bind
`include "gcd_lcm_unit_assert.svh"

module glu_check
   import glu_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    start,
   input logic                    busy,
   input logic                    rsp_valid,
   input logic [OPERAND_BITS-1:0] rsp_common_divisor
);

   `GLU_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `GLU_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_valid, busy)
   `GLU_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid && !busy)
   `GLU_ASSERT_NOW(a_divisor_nonzero, clock, reset, rsp_valid, rsp_common_divisor != '0)

endmodule

bind gcd_lcm_unit glu_check u_glu_check (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_common_divisor (rsp_common_divisor)
);

/* tb/gcd_lcm_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for gcd_lcm_unit: corner-case and random operand transfers
module gcd_lcm_unit_test;
   import glu_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int TAIL_CYCLES  = 64;
   localparam int RANDOM_PAIRS = 1430;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] first;
      logic [OPERAND_BITS-1:0] second;
      logic                    drain;
   } operand_pair_type;

   typedef struct packed {
      logic [OPERAND_BITS-1:0] divisor;
      logic [RESULT_BITS-1:0]  multiple;
   } gcd_lcm_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [OPERAND_BITS-1:0] req_first_operand = '0;
   logic [OPERAND_BITS-1:0] req_second_operand = '0;
   logic                    rsp_valid;
   logic [OPERAND_BITS-1:0] rsp_common_divisor;
   logic [RESULT_BITS-1:0]  rsp_common_multiple;

   operand_pair_type pending_pairs[$];
   gcd_lcm_type      due_results[$];
   logic             req_taken = 1'b0;
   int unsigned      burst_left = 0;
   int unsigned      gap_left = 0;
   int unsigned      idle_cycles = 0;
   int unsigned      error_count = 0;

   gcd_lcm_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .rsp_valid          (rsp_valid),
      .rsp_common_divisor (rsp_common_divisor),
      .rsp_common_multiple(rsp_common_multiple)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic gcd_lcm_type predict_gcd_lcm(logic [OPERAND_BITS-1:0] a,
                                                   logic [OPERAND_BITS-1:0] b);
      logic [OPERAND_BITS-1:0] x;
      logic [OPERAND_BITS-1:0] y;
      logic [OPERAND_BITS-1:0] r;
      gcd_lcm_type             res;
      x = a;
      y = b;
      res.divisor = OPERAND_BITS'(1);
      if (a >= OPERAND_BITS'(2)) begin
         while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
         end
         res.divisor = x;
      end
      res.multiple = (RESULT_BITS'(a) * RESULT_BITS'(b)) / RESULT_BITS'(res.divisor);
      return res;
   endfunction

   function automatic logic [OPERAND_BITS-1:0] trimmed(logic [OPERAND_BITS-1:0] v);
      return v >> $urandom_range(0, OPERAND_BITS - 1);
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      int unsigned      g;
      p.drain = 1'b0;
      p.first = OPERAND_BITS'($urandom);
      p.second = OPERAND_BITS'($urandom);
      case ($urandom_range(0, 9))
         4, 5: begin
            g = $urandom_range(1, 255);
            p.first = OPERAND_BITS'(g * $urandom_range(0, 65535 / g));
            p.second = OPERAND_BITS'(g * $urandom_range(0, 65535 / g));
         end
         6: begin
            if ($urandom_range(0, 1)) p.first = OPERAND_BITS'($urandom_range(0, 3));
            else p.second = OPERAND_BITS'($urandom_range(0, 3));
         end
         7: begin
            p.first = trimmed(p.first);
            p.second = trimmed(p.second);
         end
         8: begin
            p.second = $urandom_range(0, 1) ? p.first : p.first >> $urandom_range(1, 8);
         end
         9: begin
            p.first = trimmed(p.first) << $urandom_range(0, OPERAND_BITS - 1);
            p.second = trimmed(p.second) << $urandom_range(0, OPERAND_BITS - 1);
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic add_pair(input logic [OPERAND_BITS-1:0] a, input logic [OPERAND_BITS-1:0] b,
                           input logic drain = 1'b0);
      pending_pairs.push_back('{first: a, second: b, drain: drain});
   endtask

   always @(negedge clock) begin : driver
      logic             offer;
      operand_pair_type head;
      offer = 1'b0;
      if (!reset) begin
         if (start && req_taken) void'(pending_pairs.pop_front());
         if (start && !req_taken) begin
            offer = 1'b1;
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
         end else if (pending_pairs.size() != 0) begin
            head = pending_pairs[0];
            if (!head.drain || due_results.size() == 0) begin
               offer = 1'b1;
               req_first_operand <= head.first;
               req_second_operand <= head.second;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
      start <= offer;
   end

   always @(posedge clock) begin : monitor
      gcd_lcm_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected result divisor %0d multiple %0d", $time,
                        rsp_common_divisor, rsp_common_multiple);
               error_count++;
            end else begin
               want = due_results.pop_front();
               if (rsp_common_divisor !== want.divisor) begin
                  $display("%0t: common_divisor expected %0d, got %0d", $time,
                           want.divisor, rsp_common_divisor);
                  error_count++;
               end
               if (rsp_common_multiple !== want.multiple) begin
                  $display("%0t: common_multiple expected %0d, got %0d", $time,
                           want.multiple, rsp_common_multiple);
                  error_count++;
               end
            end
         end
         if (start && !busy)
            due_results.push_back(predict_gcd_lcm(req_first_operand, req_second_operand));
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : stimulus
      operand_pair_type p;
      add_pair(16'h0000, 16'h0000);
      add_pair(16'h0000, 16'h0001);
      add_pair(16'h0000, 16'hFFFF);
      add_pair(16'h0001, 16'h0000);
      add_pair(16'h0001, 16'h0001);
      add_pair(16'h0001, 16'hFFFF);
      add_pair(16'h0002, 16'h0000);
      add_pair(16'hFFFF, 16'h0000);
      add_pair(16'h0002, 16'h0002);
      add_pair(16'h0002, 16'h0003);
      add_pair(16'hFFFF, 16'hFFFF);
      add_pair(16'hFFFF, 16'hFFFE);
      add_pair(16'hFFFE, 16'hFFFF);
      add_pair(16'h8000, 16'h8000, 1'b1);
      add_pair(16'h8000, 16'h4000);
      add_pair(16'hFFFF, 16'h0001);
      add_pair(16'd12, 16'd18);
      add_pair(16'd18, 16'd12);
      add_pair(16'hAAAA, 16'h5555);
      add_pair(16'h5555, 16'hAAAA);
      add_pair(16'd65521, 16'd65519);
      add_pair(16'd4000, 16'd6000);
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         p = random_pair();
         p.drain = (i % 250 == 125);
         pending_pairs.push_back(p);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || start || due_results.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0 && due_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+sv
sv/glu_pkg.sv
sv/glu_dpath.sv
sv/glu_ctrl.sv
sv/gcd_lcm_unit.sv
sv/glu_check.sv
tb/gcd_lcm_unit_test.sv
